[rtl/indexed_list_store_assert.svh]
// Assertion macros shared by the indexed list store modules.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define ILS_ASSERT_SAME(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("indexed_list_store: same-cycle check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("indexed_list_store: next-cycle check failed");
`else
`define ILS_ASSERT_SAME(label, ck, rn, ante, cons)
`define ILS_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

[rtl/ils_pkg.sv]
// Types and constants shared by the indexed list store modules.
package ils_pkg;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_INS_AT    = 3'd3,
    OP_DELETE    = 3'd4
  } op_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [31:0] NO_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         position;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [7:0]         entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_WAIT,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    VD_READ,
    VD_INSERT,
    VD_DELETE,
    VD_REJECT
  } verdict_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_KM1,
    RD_KP1
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    decide;
    logic    k_init_cnt;
    logic    k_init_pos;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    mv_wr;
    logic    put_wr;
    logic    k_dec;
    logic    k_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    take_read;
  } cmd_t;

  typedef struct packed {
    verdict_t verdict;
    logic     k_gt_pos;
    logic     k1_lt_cnt;
  } stat_t;

endpackage

[rtl/ils_datapath.sv]
// Datapath: request registers, entry memory, entry counter, walk index and result.
`include "indexed_list_store_assert.svh"

module ils_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ils_pkg::in_item_t  in_item,
  input  ils_pkg::cmd_t      cmd,
  output ils_pkg::stat_t     stat,
  output ils_pkg::out_item_t out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [2:0]    op_r;
  logic [7:0]    pos_r;
  logic [31:0]   value_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] k_r;
  logic [31:0]   rdata_r;
  logic [31:0]   read_value_r;
  logic [1:0]    status_r;

  logic [31:0]   mem [CAPACITY];

  logic [7:0]    count8;
  logic          full;
  ils_pkg::verdict_t verdict;
  logic [1:0]    code;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          wr_en;

  assign count8 = 8'(count_r);
  assign full   = (count_r == CW'(CAPACITY));

  always_comb begin
    verdict = ils_pkg::VD_REJECT;
    code    = ils_pkg::ST_RANGE;
    unique case (op_r)
      ils_pkg::OP_READ: begin
        if (pos_r < count8) begin
          verdict = ils_pkg::VD_READ;
          code    = ils_pkg::ST_DONE;
        end
      end
      ils_pkg::OP_INS_FRONT, ils_pkg::OP_INS_BACK, ils_pkg::OP_INS_AT: begin
        // The range check takes precedence over the full check.
        if (pos_r > count8) begin
          code = ils_pkg::ST_RANGE;
        end else if (full) begin
          code = ils_pkg::ST_FULL;
        end else begin
          verdict = ils_pkg::VD_INSERT;
          code    = ils_pkg::ST_DONE;
        end
      end
      ils_pkg::OP_DELETE: begin
        if (pos_r < count8) begin
          verdict = ils_pkg::VD_DELETE;
          code    = ils_pkg::ST_DONE;
        end
      end
      default: begin
        verdict = ils_pkg::VD_REJECT;
        code    = ils_pkg::ST_RANGE;
      end
    endcase
  end

  assign stat.verdict   = verdict;
  assign stat.k_gt_pos  = (8'(k_r) > pos_r);
  assign stat.k1_lt_cnt = (({1'b0, k_r} + (CW + 1)'(1)) < {1'b0, count_r});

  always_comb begin
    unique case (cmd.rd_sel)
      ils_pkg::RD_POS: raddr = pos_r[AW-1:0];
      ils_pkg::RD_KM1: raddr = AW'(k_r - CW'(1));
      ils_pkg::RD_KP1: raddr = AW'(k_r + CW'(1));
      default:         raddr = pos_r[AW-1:0];
    endcase
  end

  assign wr_en = cmd.mv_wr | cmd.put_wr;
  assign waddr = cmd.put_wr ? pos_r[AW-1:0] : k_r[AW-1:0];
  assign wdata = cmd.put_wr ? value_r : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_item.operation;
      value_r <= in_item.item_value;
      unique case (in_item.operation)
        ils_pkg::OP_INS_FRONT: pos_r <= 8'd0;
        ils_pkg::OP_INS_BACK:  pos_r <= count8;
        default:               pos_r <= in_item.position;
      endcase
    end
    if (cmd.decide) begin
      status_r     <= code;
      read_value_r <= ils_pkg::NO_VALUE;
    end else if (cmd.take_read) begin
      read_value_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.k_init_cnt) begin
        k_r <= count_r;
      end else if (cmd.k_init_pos) begin
        k_r <= CW'(pos_r);
      end else if (cmd.k_dec) begin
        k_r <= k_r - CW'(1);
      end else if (cmd.k_inc) begin
        k_r <= k_r + CW'(1);
      end
    end
  end

  assign out_item.read_value  = read_value_r;
  assign out_item.status      = status_r;
  assign out_item.entry_count = count8;

  `ILS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `ILS_ASSERT_NEXT(a_count_grows, clk, rst_n, cmd.cnt_inc,
                   count_r == $past(count_r) + CW'(1))

endmodule

[rtl/ils_controller.sv]
// Controller: sequences the check, shift walk and result cycle of each request.
`include "indexed_list_store_assert.svh"

module ils_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  ils_pkg::stat_t stat,
  output ils_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_strobe
);

  ils_pkg::state_t state_r;
  ils_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ils_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ils_pkg::S_IDLE: begin
        if (start) state_nxt = ils_pkg::S_DECIDE;
      end
      ils_pkg::S_DECIDE: begin
        unique case (stat.verdict)
          ils_pkg::VD_READ:   state_nxt = ils_pkg::S_RD_WAIT;
          ils_pkg::VD_INSERT: state_nxt = ils_pkg::S_INS_CHK;
          ils_pkg::VD_DELETE: state_nxt = ils_pkg::S_DEL_CHK;
          default:            state_nxt = ils_pkg::S_DONE;
        endcase
      end
      ils_pkg::S_RD_WAIT: state_nxt = ils_pkg::S_DONE;
      ils_pkg::S_INS_CHK: begin
        state_nxt = stat.k_gt_pos ? ils_pkg::S_INS_WR : ils_pkg::S_DONE;
      end
      ils_pkg::S_INS_WR: state_nxt = ils_pkg::S_INS_CHK;
      ils_pkg::S_DEL_CHK: begin
        state_nxt = stat.k1_lt_cnt ? ils_pkg::S_DEL_WR : ils_pkg::S_DONE;
      end
      ils_pkg::S_DEL_WR: state_nxt = ils_pkg::S_DEL_CHK;
      ils_pkg::S_DONE:   state_nxt = ils_pkg::S_IDLE;
      default:           state_nxt = ils_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = ils_pkg::RD_POS;
    busy       = 1'b1;
    out_strobe = 1'b0;
    unique case (state_r)
      ils_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ils_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        unique case (stat.verdict)
          ils_pkg::VD_READ:   cmd.rd_en      = 1'b1;
          ils_pkg::VD_INSERT: cmd.k_init_cnt = 1'b1;
          ils_pkg::VD_DELETE: cmd.k_init_pos = 1'b1;
          default:            cmd.rd_en      = 1'b0;
        endcase
      end
      ils_pkg::S_RD_WAIT: cmd.take_read = 1'b1;
      ils_pkg::S_INS_CHK: begin
        // Entries at or above the insert point move up one slot, top first.
        if (stat.k_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RD_KM1;
        end else begin
          cmd.put_wr  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      ils_pkg::S_INS_WR: begin
        cmd.mv_wr = 1'b1;
        cmd.k_dec = 1'b1;
      end
      ils_pkg::S_DEL_CHK: begin
        if (stat.k1_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RD_KP1;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      ils_pkg::S_DEL_WR: begin
        cmd.mv_wr = 1'b1;
        cmd.k_inc = 1'b1;
      end
      ils_pkg::S_DONE: out_strobe = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  `ILS_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  `ILS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

endmodule

[rtl/indexed_list_store.sv]
// Top level of the indexed list store: ordered list of signed words with a count.
//
//   Channel  Handshake           Payload
//   input    start, busy         in_item  (operation, position, item_value)
//   result   out_strobe          out_item (read_value, status, entry_count)
//
// A transaction is accepted on an edge with start high and busy low; its result is on
// out_item with out_strobe high for exactly one cycle, and the receiver cannot stall it.
// From acceptance, each request is first checked; a read then waits for the memory,
// an insert moves the entries at or above the insert point and a delete the entries
// above the deleted one, each moved entry being read and then written back.
// busy falls in the cycle after the result. rst_n is synchronous and resets count and state.
module indexed_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ils_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output ils_pkg::out_item_t out_item
);

  ils_pkg::cmd_t  cmd;
  ils_pkg::stat_t stat;

  ils_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  ils_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

[tb/tb_indexed_list_store.sv]
// Testbench for indexed_list_store: random and directed list requests checked against a predictor.
`timescale 1ns / 100ps

module tb_indexed_list_store;

  localparam int CAPACITY   = 16;
  localparam int RAND_ITEMS = 1380;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_WAIT = 50;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  ils_pkg::in_item_t  in_item = '0;
  logic               out_strobe;
  ils_pkg::out_item_t out_item;

  ils_pkg::in_item_t  request_queue[$];
  ils_pkg::out_item_t predicted_replies[$];

  // Shadow copy of the list contents and its length.
  logic signed [31:0] list_words[CAPACITY];
  int                 list_len = 0;

  int mismatch_count = 0;
  int accepted_count = 0;
  int gap_left = 0;
  int idle_pct = 30;

  indexed_list_store #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  function automatic logic [1:0] place_entry(int pos, logic signed [31:0] val);
    // The range check takes precedence over the full check.
    if (pos > list_len) return ils_pkg::ST_RANGE;
    if (list_len >= CAPACITY) return ils_pkg::ST_FULL;
    for (int k = list_len; k > pos; k--) list_words[k] = list_words[k - 1];
    list_words[pos] = val;
    list_len++;
    return ils_pkg::ST_DONE;
  endfunction

  function automatic ils_pkg::out_item_t apply_request(ils_pkg::in_item_t req);
    ils_pkg::out_item_t rsp;
    int                 pos;
    rsp.read_value = ils_pkg::NO_VALUE;
    rsp.status = ils_pkg::ST_RANGE;
    pos = int'(req.position);
    case (req.operation)
      ils_pkg::OP_READ: begin
        if (pos < list_len) begin
          rsp.read_value = list_words[pos];
          rsp.status = ils_pkg::ST_DONE;
        end
      end
      ils_pkg::OP_INS_FRONT: rsp.status = place_entry(0, req.item_value);
      ils_pkg::OP_INS_BACK:  rsp.status = place_entry(list_len, req.item_value);
      ils_pkg::OP_INS_AT:    rsp.status = place_entry(pos, req.item_value);
      ils_pkg::OP_DELETE: begin
        if (pos < list_len) begin
          for (int k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
          list_len--;
          rsp.status = ils_pkg::ST_DONE;
        end
      end
      default: rsp.status = ils_pkg::ST_RANGE;
    endcase
    rsp.entry_count = 8'(list_len);
    return rsp;
  endfunction

  function automatic ils_pkg::in_item_t make_request(logic [2:0] op, logic [7:0] pos,
                                                     logic signed [31:0] val);
    ils_pkg::in_item_t req;
    req.operation = op;
    req.position = pos;
    req.item_value = val;
    return req;
  endfunction

  // Driver: presents queued requests and, until the queue runs low, inserts random idle bursts between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        predicted_replies.push_back(apply_request(in_item));
        accepted_count++;
        if (accepted_count % 100 == 0) idle_pct = $urandom_range(0, 3) * 20;
        if (request_queue.size() >= QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
          gap_left = $urandom_range(1, 13);
      end
      if (start && busy) begin
        // Hold the current transaction until the block takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_queue.size() > 0) begin
        in_item <= request_queue.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result must match the oldest prediction.
  always @(posedge clk) begin
    ils_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (predicted_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result read_value %0d status %0d count %0d",
                   out_item.read_value, out_item.status, out_item.entry_count);
      end else begin
        want = predicted_replies.pop_front();
        if (out_item.read_value !== want.read_value || out_item.status !== want.status ||
            out_item.entry_count !== want.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR at %0t: read_value exp %0d got %0d, ",
                      "status exp %0d got %0d, count exp %0d got %0d"},
                     $realtime, want.read_value, out_item.read_value, want.status,
                     out_item.status, want.entry_count, out_item.entry_count);
        end
      end
    end
  end

  initial begin
    int         mode;
    int         r;
    int         pos_pick;
    logic [2:0] op;
    logic [7:0] pos;

    // Directed requests: empty list, both value extremes, list ends, ignored positions, undefined operations.
    request_queue.push_back(make_request(ils_pkg::OP_READ, 8'd0, 32'sd5));
    request_queue.push_back(make_request(ils_pkg::OP_DELETE, 8'd0, 32'sd0));
    request_queue.push_back(make_request(ils_pkg::OP_INS_AT, 8'd1, 32'sd11));
    request_queue.push_back(make_request(ils_pkg::OP_INS_AT, 8'd0, 32'sh7FFF_FFFF));
    request_queue.push_back(make_request(ils_pkg::OP_INS_FRONT, 8'd255, 32'sh8000_0000));
    request_queue.push_back(make_request(ils_pkg::OP_INS_BACK, 8'd255, -32'sd1));
    request_queue.push_back(make_request(ils_pkg::OP_INS_AT, 8'd3, 32'sd0));
    request_queue.push_back(make_request(ils_pkg::OP_INS_AT, 8'd1, 32'($urandom)));
    request_queue.push_back(make_request(ils_pkg::OP_READ, 8'd0, 32'sd0));
    request_queue.push_back(make_request(ils_pkg::OP_READ, 8'd4, 32'sd0));
    request_queue.push_back(make_request(ils_pkg::OP_READ, 8'd5, 32'sd0));
    request_queue.push_back(make_request(ils_pkg::OP_READ, 8'd255, -32'sd1));
    request_queue.push_back(make_request(ils_pkg::OP_DELETE, 8'd255, 32'sd0));
    request_queue.push_back(make_request(ils_pkg::OP_INS_AT, 8'd6, 32'sd3));
    request_queue.push_back(make_request(ils_pkg::OP_DELETE, 8'd4, 32'sd0));
    request_queue.push_back(make_request(ils_pkg::OP_DELETE, 8'd0, 32'sd0));
    request_queue.push_back(make_request(ils_pkg::OP_DELETE, 8'd1, 32'sd0));
    request_queue.push_back(make_request(3'd5, 8'd0, 32'sd7));
    request_queue.push_back(make_request(3'd6, 8'd0, 32'sh7FFF_FFFF));
    request_queue.push_back(make_request(3'd7, 8'd1, 32'sh8000_0000));

    // Random requests in segments that lean toward filling, draining or neither.
    mode = MODE_FILL;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i > 0 && i % 60 == 0) mode = $urandom_range(MODE_FILL, MODE_MIXED);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = 3'($urandom_range(5, 7));
      end else if (mode == MODE_FILL) begin
        op = r < 18 ? ils_pkg::OP_READ : r < 38 ? ils_pkg::OP_INS_FRONT :
             r < 58 ? ils_pkg::OP_INS_BACK : r < 83 ? ils_pkg::OP_INS_AT :
             ils_pkg::OP_DELETE;
      end else if (mode == MODE_DRAIN) begin
        op = r < 23 ? ils_pkg::OP_READ : r < 30 ? ils_pkg::OP_INS_FRONT :
             r < 37 ? ils_pkg::OP_INS_BACK : r < 47 ? ils_pkg::OP_INS_AT :
             ils_pkg::OP_DELETE;
      end else begin
        op = r < 30 ? ils_pkg::OP_READ : r < 45 ? ils_pkg::OP_INS_FRONT :
             r < 60 ? ils_pkg::OP_INS_BACK : r < 78 ? ils_pkg::OP_INS_AT :
             ils_pkg::OP_DELETE;
      end
      // Mostly positions near the live range, sometimes anywhere in the field.
      pos_pick = $urandom_range(0, 99);
      if (pos_pick < 40) pos = 8'($urandom_range(0, 3));
      else if (pos_pick < 85) pos = 8'($urandom_range(0, CAPACITY));
      else pos = 8'($urandom_range(0, 255));
      request_queue.push_back(make_request(op, pos, 32'($urandom)));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || start) @(posedge clk);
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && predicted_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
